>>> rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes for the bounded deque
// Beat payload structs, action codes and status codes.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd1;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_SEARCH     = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               found;
		logic [3:0]         match_position;
		logic [4:0]         entry_count;
		logic [1:0]         status;
	} out_t;

endpackage

>>> rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search: bounded deque with membership search
// Top level: sequencer, entry memory and the output register.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A push passes through the execute state,
// a pop through the execute and pop states, and a search through the execute
// state and a scan that reads one entry per cycle through the single memory
// read port, checks it with one shared compare and ends on a match or once the
// last entry read has been compared. The result sits in an output register,
// so the next beat is taken while it waits. Push on full and pop on empty
// report a status and leave the queue as it was.
module bounded_deque_with_search import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int AW = $clog2(DEPTH);

	logic          res_valid;
	logic          res_take;
	out_t          res_data;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;
	logic          out_valid_q;
	out_t          out_q;

	bdq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_data  (res_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bdq_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/bdq_mem.sv
// ----------------------------------------------------------------------------
// bdq_mem: entry storage
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module bdq_mem import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bdq_seq.sv
// ----------------------------------------------------------------------------
// bdq_seq: deque sequencer
// Holds front index and entry count, runs push, pop and the search scan
// through one shared equality compare against the read port.
// ----------------------------------------------------------------------------
module bdq_seq import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  in_t                      in_data,
	output logic                     res_valid,
	input  logic                     res_take,
	output out_t                     res_data,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [31:0]              mem_wdata,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  logic [31:0]              mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_POP  = 5'b00100,
		S_SCAN = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t        state_q;
	logic [2:0]    act_q;
	logic [31:0]   val_q;
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] pos_q;
	logic          pend_q;
	logic [31:0]   vout_q;
	logic          found_q;
	logic [AW-1:0] rpos_q;
	logic [1:0]    status_q;

	logic          full;
	logic          empty;
	logic          hit;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [CW-1:0] count_m1;
	logic [31:0]   cnt_w;
	logic [31:0]   pos_w;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, front} + {1'b0, off};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign hit       = pend_q && (mem_rdata == val_q);
	assign front_dec = (front_q == '0) ? DEPTH_M1 : front_q - 1'b1;
	assign front_inc = (front_q == DEPTH_M1) ? '0 : front_q + 1'b1;
	assign count_m1  = count_q - 1'b1;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign cnt_w     = 32'(count_q);
	assign pos_w     = 32'(rpos_q);

	always_comb begin
		res_data.value_out      = vout_q;
		res_data.found          = found_q;
		res_data.match_position = pos_w[3:0];
		res_data.entry_count    = cnt_w[4:0];
		res_data.status         = status_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = '0;
		mem_raddr = '0;
		mem_wdata = val_q;
		case (state_q)
			S_EXEC: begin
				case (act_q)
					ACT_PUSH_FRONT: begin
						mem_we    = !full;
						mem_waddr = front_dec;
					end
					ACT_PUSH_BACK: begin
						mem_we    = !full;
						mem_waddr = slot_of(front_q, count_q[AW-1:0]);
					end
					ACT_POP_FRONT: begin
						mem_re    = !empty;
						mem_raddr = front_q;
					end
					ACT_POP_BACK: begin
						mem_re    = !empty;
						mem_raddr = slot_of(front_q, count_m1[AW-1:0]);
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (!hit && (idx_q < count_q)) begin
					mem_re    = 1'b1;
					mem_raddr = slot_of(front_q, idx_q[AW-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= in_data.action;
						val_q   <= in_data.value_in;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					vout_q   <= '0;
					found_q  <= 1'b0;
					rpos_q   <= '0;
					status_q <= ST_OK;
					state_q  <= S_DONE;
					case (act_q)
						ACT_PUSH_FRONT: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								front_q <= front_dec;
								count_q <= count_q + 1'b1;
							end
						end
						ACT_PUSH_BACK: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						ACT_POP_FRONT, ACT_POP_BACK: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_POP;
							end
						end
						ACT_SEARCH: begin
							idx_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SCAN;
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					vout_q  <= mem_rdata;
					count_q <= count_m1;
					if (act_q == ACT_POP_FRONT) begin
						front_q <= front_inc;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						rpos_q  <= pos_q;
						pend_q  <= 1'b0;
						state_q <= S_DONE;
					end else if (idx_q < count_q) begin
						pend_q <= 1'b1;
						pos_q  <= idx_q[AW-1:0];
						idx_q  <= idx_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> verif/bounded_deque_with_search_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_deque_with_search_test: self-checking bench for the bounded deque
// A short table of directed beats covers the empty and full corners, the
// value extremes, search hit and miss and the unused action codes. About 1200
// random beats follow, steered between fill, drain and mixed phases so the
// queue keeps sweeping from empty to full. A software deque predicts every
// result. Both handshakes idle at random, with calm stretches in between.
// ---------------------------------------------------------------------------
module bounded_deque_with_search_test import bdq_pkg::*;;

	localparam int QD = DEPTH_DEFAULT;
	localparam int AW = $clog2(QD);
	localparam int RANDOM_BEATS = 1200;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = QD + 16;
	localparam int ROWS = 14;
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] value;
		logic [4:0]  reps;
		logic        typed;
		out_t        want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	logic signed [31:0] held_values [QD];
	logic [AW-1:0] head_slot = '0;
	logic [AW:0] held_count = '0;
	out_t pending_results [$];
	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	logic signed [31:0] value_pool [8] = '{
		32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
		32'sd1, 32'sd42, -32'sd42, 32'sh55555555
	};

	// rows with reps > 1 push value, value + 1, ...
	plan_row_t plan [ROWS] = '{
		'{ACT_POP_FRONT,  32'd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd0, ST_EMPTY}},
		'{ACT_POP_BACK,   32'd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd0, ST_EMPTY}},
		'{ACT_SEARCH,     32'd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd0, ST_OK}},
		'{ACT_SPARE_LO,   32'hffffffff, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd0, ST_OK}},
		'{ACT_PUSH_BACK,  32'h7fffffff, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd1, ST_OK}},
		'{ACT_PUSH_FRONT, 32'h80000000, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd2, ST_OK}},
		'{ACT_PUSH_BACK,  32'd100, 5'd14, 1'b0, '0},
		'{ACT_PUSH_BACK,  32'd5, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd16, ST_FULL}},
		'{ACT_PUSH_FRONT, 32'd5, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd16, ST_FULL}},
		'{ACT_SEARCH,     32'h7fffffff, 5'd1, 1'b1, '{32'sd0, 1'b1, 4'd1, 5'd16, ST_OK}},
		'{ACT_SEARCH,     32'd113, 5'd1, 1'b1, '{32'sd0, 1'b1, 4'd15, 5'd16, ST_OK}},
		'{ACT_SPARE_HI,   32'd0, 5'd1, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd16, ST_OK}},
		'{ACT_POP_BACK,   32'd0, 5'd1, 1'b1, '{32'sd113, 1'b0, 4'd0, 5'd15, ST_OK}},
		'{ACT_POP_FRONT,  32'd0, 5'd1, 1'b1, '{32'sh80000000, 1'b0, 4'd0, 5'd14, ST_OK}}
	};

	bounded_deque_with_search #(.DEPTH(QD)) dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data
	);

	always #1 clk = ~clk;

	function automatic out_t deque_apply(in_t beat);
		out_t res;
		logic [AW-1:0] slot;
		int i;
		res = '0;
		case (beat.action)
			ACT_PUSH_FRONT: begin
				if (held_count == QD) begin
					res.status = ST_FULL;
				end else begin
					head_slot = head_slot - 1'b1;
					held_values[head_slot] = beat.value_in;
					held_count = held_count + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.value_out = held_values[head_slot];
					head_slot = head_slot + 1'b1;
					held_count = held_count - 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (held_count == QD) begin
					res.status = ST_FULL;
				end else begin
					slot = AW'(head_slot + held_count);
					held_values[slot] = beat.value_in;
					held_count = held_count + 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					slot = AW'(head_slot + held_count - 1'b1);
					res.value_out = held_values[slot];
					held_count = held_count - 1'b1;
				end
			end
			ACT_SEARCH: begin
				for (i = 0; i < held_count; i++) begin
					slot = AW'(head_slot + i);
					if (!res.found && held_values[slot] == beat.value_in) begin
						res.found = 1'b1;
						res.match_position = 4'(i);
					end
				end
			end
			default: ;
		endcase
		res.entry_count = held_count;
		return res;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_result(input out_t got);
		out_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			flag_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
		end else begin
			want = pending_results[0];
			pending_results.delete(0);
			if (got.value_out !== want.value_out)
				flag_mismatch($sformatf("result %0d value_out %0d, expected %0d",
					results_seen, got.value_out, want.value_out));
			if (got.found !== want.found)
				flag_mismatch($sformatf("result %0d found %0b, expected %0b",
					results_seen, got.found, want.found));
			if (got.match_position !== want.match_position)
				flag_mismatch($sformatf("result %0d match_position %0d, expected %0d",
					results_seen, got.match_position, want.match_position));
			if (got.entry_count !== want.entry_count)
				flag_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
					results_seen, got.entry_count, want.entry_count));
			if (got.status !== want.status)
				flag_mismatch($sformatf("result %0d status %0d, expected %0d",
					results_seen, got.status, want.status));
		end
	endtask

	// drive one beat, wait for it to be taken, then log what it should produce
	task automatic issue_beat(input in_t beat, input bit typed, input out_t want);
		int gap;
		out_t res;
		@(negedge clk);
		if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!in_ready);
		res = deque_apply(beat);
		pending_results.insert(pending_results.size(), typed ? want : res);
	endtask

	initial begin
		in_t beat;
		int n;
		int k;
		int mode_left;
		int fill_mode;
		int push_cut;
		int pop_cut;
		int roll;
		logic [AW-1:0] slot;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < ROWS; n++) begin
			for (k = 0; k < plan[n].reps; k++) begin
				beat.action = plan[n].action;
				beat.value_in = plan[n].value + k;
				issue_beat(beat, plan[n].typed, plan[n].want);
			end
		end

		// fill, drain and mixed phases keep the level moving end to end
		mode_left = 0;
		fill_mode = 0;
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (mode_left == 0) begin
				fill_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(15, 60);
			end
			mode_left--;
			push_cut = (fill_mode == 0) ? 55 : (fill_mode == 1) ? 15 : 35;
			pop_cut = push_cut + ((fill_mode == 0) ? 15 : (fill_mode == 1) ? 55 : 35);
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 9) < 6)
				beat.value_in = value_pool[$urandom_range(0, 7)];
			else
				beat.value_in = $urandom;
			if (roll < push_cut) begin
				beat.action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
			end else if (roll < pop_cut) begin
				beat.action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
			end else if (roll < 97) begin
				beat.action = ACT_SEARCH;
				if (held_count != 0 && $urandom_range(0, 1)) begin
					slot = AW'(head_slot + $urandom_range(0, held_count - 1));
					beat.value_in = held_values[slot];
				end
			end else begin
				beat.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
			end
			issue_beat(beat, 1'b0, '0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
			gap = out_calm ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_result(out_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no beat moved for %0d cycles", $time, quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

>>> files.f
rtl/bdq_pkg.sv
rtl/bdq_mem.sv
rtl/bdq_seq.sv
rtl/bounded_deque_with_search.sv
verif/bounded_deque_with_search_test.sv
